FILE: rtl/assert_macros.svh
// assertion macros for the rtl files, included by acf_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic concurrent check on a given clock and active-low reset
`define ACF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("acf assertion failed");

// check on the block clock and reset
`define ACF_CHECK(lbl, prop) `ACF_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/acf_pkg.sv
// types, constants and helper functions of the attitude filter
`default_nettype none
package acf_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int STATE_BITS  = 32;
  localparam int AXES        = 3;
  localparam int PERIOD_BITS = 24;
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int DIV_W       = 38;
  localparam int DIVR_W      = 5;
  localparam int OUT_BITS    = 16;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [MUL_W-1:0]       mul_w_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [DIV_W-1:0]       div_w_t;
  typedef logic signed [OUT_BITS-1:0]    cdeg_t;
  typedef logic [PERIOD_BITS-1:0]        period_t;

  // register indexes
  localparam logic REG_FILTER_SEL  = 1'b0;
  localparam logic REG_CORR_FACTOR = 1'b1;

  localparam logic [2:0] FILTER_SEL_RESET  = 3'd2;
  localparam logic [3:0] CORR_FACTOR_RESET = 4'd7;
  localparam logic [2:0] FILTER_SEL_MAX    = 3'd6;
  localparam logic [3:0] CORR_FACTOR_MAX   = 4'd10;
  localparam logic [4:0] CORR_BASE         = 5'd11;

  localparam mul_w_t MUL_THETA_K = 33'sd239887;
  localparam mul_w_t MUL_ANGLE_K = 33'sd43254;
  localparam mul_w_t MUL_DEG90   = 33'sd90;
  localparam mul_w_t MUL_CDEG    = -33'sd100;

  localparam prod_t THETA_MAX = 66'sd140552805;
  localparam prod_t DEG180    = 66'sd94371840;
  localparam state_t ONE_Q29  = 32'sd536870912;
  localparam state_t HALF_Q29 = 32'sd268435456;
  localparam logic [PERIOD_BITS-1:0] MAG_LOW  = 24'd11837;
  localparam logic [PERIOD_BITS-1:0] MAG_HIGH = 24'd21668;

  typedef struct packed {
    logic [2:0] filter_sel;
    logic [3:0] corr_factor;
  } cfg_t;

  typedef struct packed {
    logic             start;
    div_w_t           dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    div_w_t quotient;
  } div_rsp_t;

  // low-pass divisor table
  function automatic logic [DIVR_W-1:0] lpf_div(logic [2:0] sel);
    logic [DIVR_W-1:0] d;
    unique case (sel)
      3'd0:    d = 5'd23;
      3'd1:    d = 5'd12;
      3'd2:    d = 5'd6;
      3'd3:    d = 5'd4;
      3'd4:    d = 5'd3;
      3'd5:    d = 5'd2;
      default: d = 5'd1;
    endcase
    return d;
  endfunction

  // arithmetic shift right rounding toward zero
  function automatic prod_t trunc_shr(prod_t x, int unsigned k);
    prod_t bias;
    bias = x[PROD_W-1] ? ((prod_t'(1) <<< k) - prod_t'(1)) : '0;
    return (x + bias) >>> k;
  endfunction

  function automatic state_t sat_state(prod_t x);
    state_t r;
    if ((&x[PROD_W-1:STATE_BITS-1]) || !(|x[PROD_W-1:STATE_BITS-1])) begin
      r = x[STATE_BITS-1:0];
    end else if (x[PROD_W-1]) begin
      r = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic cdeg_t sat_cdeg(prod_t x);
    cdeg_t r;
    if ((&x[PROD_W-1:OUT_BITS-1]) || !(|x[PROD_W-1:OUT_BITS-1])) begin
      r = x[OUT_BITS-1:0];
    end else if (x[PROD_W-1]) begin
      r = {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/acf_if.sv
// valid/ready channel interfaces for sensor items and attitude results
`default_nettype none
interface acf_in_if;
  logic               valid;
  logic               ready;
  acf_pkg::sample_t   acc_roll;
  acf_pkg::sample_t   acc_pitch;
  acf_pkg::sample_t   acc_vertical;
  acf_pkg::sample_t   gyro_roll;
  acf_pkg::sample_t   gyro_pitch;
  acf_pkg::sample_t   gyro_yaw;
  acf_pkg::period_t   loop_period;

  modport source (output valid, acc_roll, acc_pitch, acc_vertical, gyro_roll,
                  gyro_pitch, gyro_yaw, loop_period, input ready);
  modport sink (input valid, acc_roll, acc_pitch, acc_vertical, gyro_roll,
                gyro_pitch, gyro_yaw, loop_period, output ready);
endinterface

interface acf_out_if;
  logic            valid;
  logic            ready;
  acf_pkg::cdeg_t  roll_centideg;
  acf_pkg::cdeg_t  pitch_centideg;
  logic            correction_applied;

  modport source (output valid, roll_centideg, pitch_centideg, correction_applied,
                  input ready);
  modport sink (input valid, roll_centideg, pitch_centideg, correction_applied,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/acf_mul.sv
// shared signed multiplier with registered product
`default_nettype none
module acf_mul (
  input  wire logic            clk_i,
  input  acf_pkg::mul_w_t      a_i,
  input  acf_pkg::mul_w_t      b_i,
  output acf_pkg::prod_t       p_o
);
  acf_pkg::prod_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= acf_pkg::prod_t'(a_i) * acf_pkg::prod_t'(b_i);
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

FILE: rtl/acf_div.sv
// radix-2 restoring divider, one quotient bit per cycle, rounds toward zero
`default_nettype none
module acf_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  acf_pkg::div_req_t  req_i,
  output acf_pkg::div_rsp_t  rsp_o
);
  localparam int MAG_W = acf_pkg::DIV_W - 1;
  localparam int CNT_W = $clog2(MAG_W);

  logic                        busy_q, done_q, neg_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [MAG_W-1:0]            mq_q;
  logic [acf_pkg::DIVR_W-1:0]  rem_q, dv_q;
  logic [acf_pkg::DIVR_W:0]    trial_w;
  logic                        fit_w;
  acf_pkg::div_w_t             abs_w;

  assign abs_w   = req_i.dividend[acf_pkg::DIV_W-1] ? -req_i.dividend : req_i.dividend;
  assign trial_w = {rem_q, mq_q[MAG_W-1]};
  assign fit_w   = trial_w >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MAG_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mq_q  <= abs_w[MAG_W-1:0];
      rem_q <= '0;
      dv_q  <= req_i.divisor;
      neg_q <= req_i.dividend[acf_pkg::DIV_W-1];
    end else if (busy_q) begin
      rem_q <= fit_w ? acf_pkg::DIVR_W'(trial_w - {1'b0, dv_q})
                     : trial_w[acf_pkg::DIVR_W-1:0];
      mq_q  <= {mq_q[MAG_W-2:0], fit_w};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -acf_pkg::div_w_t'({1'b0, mq_q})
                                : acf_pkg::div_w_t'({1'b0, mq_q});
endmodule
`default_nettype wire

FILE: rtl/acf_core.sv
// sequencer and datapath of the attitude filter around the shared units
`default_nettype none
`include "assert_macros.svh"
module acf_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  acf_pkg::cfg_t   cfg_i,
  acf_in_if.sink          in_i,
  acf_out_if.source       out_o
);
  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_SM_MUL   = 5'd1;
  localparam logic [4:0] ST_SM_DIV   = 5'd2;
  localparam logic [4:0] ST_SM_WAIT  = 5'd3;
  localparam logic [4:0] ST_MAG_MUL  = 5'd4;
  localparam logic [4:0] ST_MAG_ACC  = 5'd5;
  localparam logic [4:0] ST_CORR     = 5'd6;
  localparam logic [4:0] ST_ANG_MUL  = 5'd7;
  localparam logic [4:0] ST_ANG_DIV  = 5'd8;
  localparam logic [4:0] ST_ANG_WAIT = 5'd9;
  localparam logic [4:0] ST_TH_MUL   = 5'd10;
  localparam logic [4:0] ST_TH_HI    = 5'd11;
  localparam logic [4:0] ST_TH_LO    = 5'd12;
  localparam logic [4:0] ST_TH_SUM   = 5'd13;
  localparam logic [4:0] ST_COS_MUL  = 5'd14;
  localparam logic [4:0] ST_COS_SET  = 5'd15;
  localparam logic [4:0] ST_R1A      = 5'd16;
  localparam logic [4:0] ST_R1B      = 5'd17;
  localparam logic [4:0] ST_R1C      = 5'd18;
  localparam logic [4:0] ST_R2B      = 5'd19;
  localparam logic [4:0] ST_R2C      = 5'd20;
  localparam logic [4:0] ST_EX_MUL   = 5'd21;
  localparam logic [4:0] ST_EX_SET   = 5'd22;
  localparam logic [4:0] ST_CD_MUL   = 5'd23;
  localparam logic [4:0] ST_CD_SET   = 5'd24;
  localparam logic [4:0] ST_OUT      = 5'd25;

  localparam logic [1:0] AX_LAST = 2'(acf_pkg::AXES - 1);

  logic [4:0] state_q, state_d;
  logic [1:0] ax_q, rot_q;

  acf_pkg::sample_t acc_q [acf_pkg::AXES];
  acf_pkg::state_t  rate_q [acf_pkg::AXES];
  acf_pkg::state_t  smooth_q [acf_pkg::AXES];
  acf_pkg::state_t  up_q [acf_pkg::AXES];
  acf_pkg::state_t  eul_q [2];
  acf_pkg::period_t period_q;
  logic [acf_pkg::PERIOD_BITS-1:0] mag_q;
  logic             corr_q, ovf_q;
  logic [44:0]      mp_q;
  acf_pkg::prod_t   sum_q;
  acf_pkg::state_t  theta_q, cos_q, na_q;
  acf_pkg::cdeg_t   res_q [2];

  logic           out_valid_q;
  acf_pkg::cdeg_t out_roll_q, out_pitch_q;
  logic           out_corr_q;

  acf_pkg::mul_w_t  mul_a, mul_b;
  acf_pkg::prod_t   p_w;
  acf_pkg::div_req_t div_req;
  acf_pkg::div_rsp_t div_rsp;

  logic [2:0]                  sel_w;
  logic [3:0]                  cf_w;
  logic [acf_pkg::DIVR_W-1:0]  d_w, cdiv_w;
  logic [1:0]                  ra_w, rb_w, rr_w;
  acf_pkg::state_t             va_w, vb_w, rate_w;
  logic [acf_pkg::STATE_BITS-1:0] rmag_w;
  acf_pkg::prod_t sm_num_w, ang_num_w, tsum_w, tt_w, tm_w, ex_w, ex_m_w;
  acf_pkg::state_t theta_w, nb_w;
  logic out_free_w, accept_w;

  // configuration clamps
  assign sel_w  = (cfg_i.filter_sel > acf_pkg::FILTER_SEL_MAX) ? acf_pkg::FILTER_SEL_MAX
                                                               : cfg_i.filter_sel;
  assign cf_w   = (cfg_i.corr_factor > acf_pkg::CORR_FACTOR_MAX) ? acf_pkg::CORR_FACTOR_MAX
                                                                 : cfg_i.corr_factor;
  assign d_w    = acf_pkg::lpf_div(sel_w);
  assign cdiv_w = acf_pkg::CORR_BASE - {1'b0, cf_w};

  // rotation order: pitch (y,z), roll (x,z), yaw (x,y)
  assign ra_w = (rot_q == 2'd0) ? 2'd1 : 2'd0;
  assign rb_w = (rot_q == 2'd2) ? 2'd1 : 2'd2;
  assign rr_w = (rot_q == 2'd0) ? 2'd1 : ((rot_q == 2'd1) ? 2'd0 : 2'd2);
  assign va_w   = up_q[ra_w];
  assign vb_w   = up_q[rb_w];
  assign rate_w = rate_q[rr_w];
  assign rmag_w = rate_w[acf_pkg::STATE_BITS-1] ? acf_pkg::STATE_BITS'(-rate_w) : rate_w;

  assign sm_num_w  = p_w - (acf_pkg::prod_t'(acc_q[ax_q]) <<< 19);
  assign ang_num_w = acf_pkg::prod_t'(eul_q[ax_q[0]]) - acf_pkg::trunc_shr(p_w, 16);
  assign tsum_w    = sum_q + p_w;
  assign tt_w      = tsum_w >>> 35;
  assign tm_w      = (ovf_q || tt_w > acf_pkg::THETA_MAX) ? acf_pkg::THETA_MAX : tt_w;
  assign theta_w   = rate_w[acf_pkg::STATE_BITS-1] ? -acf_pkg::state_t'(tm_w[31:0])
                                                   : acf_pkg::state_t'(tm_w[31:0]);
  assign nb_w      = acf_pkg::sat_state(acf_pkg::trunc_shr(sum_q + p_w, 29));
  assign ex_w      = acf_pkg::trunc_shr(p_w, 10);
  // inverted flip when upside down
  assign ex_m_w    = (ex_w > acf_pkg::prod_t'(0)) ? acf_pkg::DEG180 - ex_w
                                                  : -acf_pkg::DEG180 - ex_w;

  assign out_free_w = !out_valid_q || out_o.ready;
  assign accept_w   = in_i.valid && (state_q == ST_IDLE);

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SM_MUL: begin
        mul_a = acf_pkg::mul_w_t'(smooth_q[ax_q]);
        mul_b = acf_pkg::mul_w_t'({1'b0, d_w - 1'b1});
      end
      ST_MAG_MUL: begin
        mul_a = acf_pkg::mul_w_t'(acc_q[ax_q]);
        mul_b = acf_pkg::mul_w_t'(acc_q[ax_q]);
      end
      ST_ANG_MUL: begin
        mul_a = acf_pkg::mul_w_t'(smooth_q[ax_q]);
        mul_b = acf_pkg::MUL_ANGLE_K;
      end
      ST_TH_MUL: begin
        mul_a = acf_pkg::mul_w_t'({1'b0, rmag_w});
        mul_b = acf_pkg::mul_w_t'({9'b0, period_q});
      end
      ST_TH_HI: begin
        mul_a = acf_pkg::mul_w_t'({11'b0, p_w[44:23]});
        mul_b = acf_pkg::MUL_THETA_K;
      end
      ST_TH_LO: begin
        mul_a = acf_pkg::mul_w_t'({10'b0, mp_q[22:0]});
        mul_b = acf_pkg::MUL_THETA_K;
      end
      ST_COS_MUL: begin
        mul_a = acf_pkg::mul_w_t'(theta_q);
        mul_b = acf_pkg::mul_w_t'(theta_q);
      end
      ST_R1A: begin
        mul_a = acf_pkg::mul_w_t'(va_w);
        mul_b = acf_pkg::mul_w_t'(cos_q);
      end
      ST_R1B: begin
        mul_a = acf_pkg::mul_w_t'(vb_w);
        mul_b = acf_pkg::mul_w_t'(theta_q);
      end
      ST_R1C: begin
        mul_a = acf_pkg::mul_w_t'(va_w);
        mul_b = acf_pkg::mul_w_t'(theta_q);
      end
      ST_R2B: begin
        mul_a = acf_pkg::mul_w_t'(vb_w);
        mul_b = acf_pkg::mul_w_t'(cos_q);
      end
      ST_EX_MUL: begin
        mul_a = acf_pkg::mul_w_t'(up_q[ax_q]);
        mul_b = acf_pkg::MUL_DEG90;
      end
      ST_CD_MUL: begin
        mul_a = acf_pkg::mul_w_t'(eul_q[ax_q[0]]);
        mul_b = acf_pkg::MUL_CDEG;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = sm_num_w[acf_pkg::DIV_W-1:0];
    div_req.divisor  = d_w;
    if (state_q == ST_SM_DIV) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_ANG_DIV) begin
      div_req.start    = 1'b1;
      div_req.dividend = ang_num_w[acf_pkg::DIV_W-1:0];
      div_req.divisor  = cdiv_w;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_i.valid) state_d = ST_SM_MUL;
      ST_SM_MUL:   state_d = ST_SM_DIV;
      ST_SM_DIV:   state_d = ST_SM_WAIT;
      ST_SM_WAIT:  if (div_rsp.done) state_d = (ax_q == AX_LAST) ? ST_MAG_MUL : ST_SM_MUL;
      ST_MAG_MUL:  state_d = ST_MAG_ACC;
      ST_MAG_ACC:  state_d = (ax_q == AX_LAST) ? ST_CORR : ST_MAG_MUL;
      ST_CORR:     state_d = ((mag_q > acf_pkg::MAG_LOW) && (mag_q < acf_pkg::MAG_HIGH) &&
                              (up_q[2] > acf_pkg::HALF_Q29)) ? ST_ANG_MUL : ST_TH_MUL;
      ST_ANG_MUL:  state_d = ST_ANG_DIV;
      ST_ANG_DIV:  state_d = ST_ANG_WAIT;
      ST_ANG_WAIT: if (div_rsp.done) state_d = ax_q[0] ? ST_TH_MUL : ST_ANG_MUL;
      ST_TH_MUL:   state_d = ST_TH_HI;
      ST_TH_HI:    state_d = ST_TH_LO;
      ST_TH_LO:    state_d = ST_TH_SUM;
      ST_TH_SUM:   state_d = ST_COS_MUL;
      ST_COS_MUL:  state_d = ST_COS_SET;
      ST_COS_SET:  state_d = ST_R1A;
      ST_R1A:      state_d = ST_R1B;
      ST_R1B:      state_d = ST_R1C;
      ST_R1C:      state_d = ST_R2B;
      ST_R2B:      state_d = ST_R2C;
      ST_R2C:      state_d = (rot_q == 2'd2) ? ST_EX_MUL : ST_TH_MUL;
      ST_EX_MUL:   state_d = ST_EX_SET;
      ST_EX_SET:   state_d = ax_q[0] ? ST_CD_MUL : ST_EX_MUL;
      ST_CD_MUL:   state_d = ST_CD_SET;
      ST_CD_SET:   state_d = ax_q[0] ? ST_OUT : ST_CD_MUL;
      ST_OUT:      if (out_free_w) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_q        <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < acf_pkg::AXES; i++) begin
        smooth_q[i] <= '0;
        up_q[i]     <= '0;
      end
      up_q[2]  <= acf_pkg::ONE_Q29;
      eul_q[0] <= '0;
      eul_q[1] <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (accept_w) ax_q <= '0;
        ST_SM_WAIT: if (div_rsp.done) begin
          smooth_q[ax_q] <= acf_pkg::sat_state(acf_pkg::prod_t'(div_rsp.quotient));
          ax_q <= (ax_q == AX_LAST) ? 2'd0 : ax_q + 2'd1;
        end
        ST_MAG_ACC: ax_q <= (ax_q == AX_LAST) ? 2'd0 : ax_q + 2'd1;
        ST_CORR: begin
          ax_q  <= '0;
          rot_q <= '0;
        end
        ST_ANG_WAIT: if (div_rsp.done) ax_q <= 2'd1;
        ST_R2C: begin
          up_q[ra_w] <= na_q;
          up_q[rb_w] <= nb_w;
          rot_q <= rot_q + 2'd1;
          ax_q  <= '0;
        end
        ST_EX_SET: begin
          eul_q[ax_q[0]] <= acf_pkg::sat_state(up_q[2][acf_pkg::STATE_BITS-1] ? ex_m_w : ex_w);
          ax_q <= ax_q[0] ? 2'd0 : 2'd1;
        end
        ST_CD_SET: ax_q <= ax_q[0] ? 2'd0 : 2'd1;
        ST_OUT: if (out_free_w) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // item and scratch registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (accept_w) begin
        acc_q[0]  <= in_i.acc_roll;
        acc_q[1]  <= in_i.acc_pitch;
        acc_q[2]  <= in_i.acc_vertical;
        rate_q[0] <= acf_pkg::state_t'(in_i.gyro_roll) <<< 19;
        rate_q[1] <= acf_pkg::state_t'(in_i.gyro_pitch) <<< 19;
        rate_q[2] <= acf_pkg::state_t'(in_i.gyro_yaw) <<< 19;
        period_q  <= in_i.loop_period;
        mag_q     <= '0;
      end
      ST_MAG_ACC: mag_q <= mag_q + p_w[acf_pkg::PERIOD_BITS-1:0];
      ST_CORR: corr_q <= (mag_q > acf_pkg::MAG_LOW) && (mag_q < acf_pkg::MAG_HIGH) &&
                         (up_q[2] > acf_pkg::HALF_Q29);
      ST_ANG_WAIT: if (div_rsp.done) begin
        rate_q[ax_q] <= acf_pkg::sat_state(acf_pkg::prod_t'(rate_q[ax_q]) +
                                           acf_pkg::prod_t'(div_rsp.quotient));
      end
      ST_TH_HI: begin
        mp_q  <= p_w[44:0];
        ovf_q <= |p_w[acf_pkg::PROD_W-1:45];
      end
      ST_TH_LO:   sum_q   <= p_w <<< 23;
      ST_TH_SUM:  theta_q <= theta_w;
      ST_COS_SET: cos_q   <= acf_pkg::ONE_Q29 - acf_pkg::state_t'(p_w[61:30]);
      ST_R1B:     sum_q   <= p_w;
      ST_R1C:     na_q    <= acf_pkg::sat_state(acf_pkg::trunc_shr(sum_q - p_w, 29));
      ST_R2B:     sum_q   <= p_w;
      ST_CD_SET:  res_q[ax_q[0]] <= acf_pkg::sat_cdeg(acf_pkg::trunc_shr(p_w, 19));
      ST_OUT: if (out_free_w) begin
        out_roll_q  <= res_q[0];
        out_pitch_q <= res_q[1];
        out_corr_q  <= corr_q;
      end
      default: ;
    endcase
  end

  acf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_w)
  );

  acf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready               = (state_q == ST_IDLE);
  assign out_o.valid              = out_valid_q;
  assign out_o.roll_centideg      = out_roll_q;
  assign out_o.pitch_centideg     = out_pitch_q;
  assign out_o.correction_applied = out_corr_q;

  `ACF_CHECK(a_div_start_idle, div_req.start |-> !div_rsp.busy)
  `ACF_CHECK(a_accept_starts, (in_i.valid && in_i.ready) |=> (state_q == ST_SM_MUL))
  `ACF_CHECK(a_result_load, (state_q == ST_OUT && out_free_w) |=> (out_valid_q && state_q == ST_IDLE))
endmodule
`default_nettype wire

FILE: rtl/attitude_complementary_filter_unit.sv
// top level of the attitude complementary filter with its register port
// usage:
// - in_i carries one sensor transaction: three accelerometer axes, three gyro
//   rates and the loop period; ready is high only while the sequencer is idle
// - out_o carries one result transaction per input: roll and pitch in
//   centidegrees (times -100) and the correction flag
// - each item runs through one shared 33x33 multiplier and one bit-serial
//   divider; a quotient takes a start, 37 steps and a finish, three
//   quotients for smoothing and two more when the correction is taken
// - the result sits in an output register; the next item is accepted while
//   it waits, and a stalled receiver only holds the sequencer at its final step
// - reset clears the filter state (smoothed acceleration and angles zero, up
//   vector straight up) and loads filter select 2 and correction factor 7
// - registers: byte 0 filter select, byte 4 correction factor; write them
//   only while idle
`default_nettype none
module attitude_complementary_filter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  acf_in_if.sink           in_i,
  acf_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  acf_pkg::cfg_t cfg_q;

  // register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_sel  <= acf_pkg::FILTER_SEL_RESET;
      cfg_q.corr_factor <= acf_pkg::CORR_FACTOR_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        acf_pkg::REG_FILTER_SEL:  cfg_q.filter_sel  <= pwdata[2:0];
        acf_pkg::REG_CORR_FACTOR: cfg_q.corr_factor <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    unique case (paddr[2])
      acf_pkg::REG_FILTER_SEL:  prdata = {29'b0, cfg_q.filter_sel};
      acf_pkg::REG_CORR_FACTOR: prdata = {28'b0, cfg_q.corr_factor};
      default:                  prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  acf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .out_o  (out_o)
  );
endmodule
`default_nettype wire
